// File: hdl/b64sc_pkg.sv
// ============================================================================
// b64sc_pkg: shared types and functions for the base64 stream codec
// Descriptor passed from the front end to the back end, and the
// alphabet conversion functions in both directions.
// ============================================================================
package b64sc_pkg;

    localparam int MAX_RESULTS = 4;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } b64sc_mode_t;

    localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

    // residual bit counts
    localparam logic [2:0] HELD_0 = 3'd0;
    localparam logic [2:0] HELD_2 = 3'd2;
    localparam logic [2:0] HELD_4 = 3'd4;
    localparam logic [2:0] HELD_6 = 3'd6;

    // One input item's worth of results
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] chars;
        logic [1:0]                  last_idx;    // number of results minus one
        logic                        data_valid;
        logic                        run_last;
    } b64sc_desc_t;

    function automatic logic [7:0] b64sc_enc_char(input logic [5:0] v);
        logic [7:0] v8;
        v8 = {2'b00, v};
        if (v < 6'd26)
            return 8'h41 + v8;
        else if (v < 6'd52)
            return 8'h61 + (v8 - 8'd26);
        else if (v < 6'd62)
            return 8'h30 + (v8 - 8'd52);
        else if (v == 6'd62)
            return 8'h2B;
        else
            return 8'h2F;
    endfunction

    // returns {symbol ok, 6-bit value}
    function automatic logic [6:0] b64sc_dec_char(input logic [7:0] ch);
        if (ch >= 8'h41 && ch <= 8'h5A)
            return {1'b1, 6'(ch - 8'h41)};
        else if (ch >= 8'h61 && ch <= 8'h7A)
            return {1'b1, 6'(ch - 8'h61 + 8'd26)};
        else if (ch >= 8'h30 && ch <= 8'h39)
            return {1'b1, 6'(ch - 8'h30 + 8'd52)};
        else if (ch == 8'h2B)
            return {1'b1, 6'd62};
        else if (ch == 8'h2F)
            return {1'b1, 6'd63};
        else
            return 7'd0;
    endfunction

endpackage

// File: hdl/b64sc_front.sv
// ============================================================================
// b64sc_front: input stage of the base64 stream codec
// Accepts items, holds the mode and leftover bits, and builds one
// result descriptor per item that produces anything.
// ============================================================================
module b64sc_front
    import b64sc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_end_of_string,
    output logic        desc_valid,
    input  logic        desc_ready,
    output b64sc_desc_t desc
);

    b64sc_mode_t mode_reg;
    logic [5:0]  res_bits_reg, res_bits_next;
    logic [2:0]  res_cnt_reg, res_cnt_next;

    logic        accept;
    logic        has_result;
    logic [6:0]  dec;
    logic [5:0]  sym;
    logic        sym_ok;
    logic [5:0]  tail;

    assign s_ready = desc_ready;
    assign accept  = s_valid && s_ready;
    assign dec     = b64sc_dec_char(s_in_byte);
    assign sym_ok  = dec[6];
    assign sym     = dec[5:0];

    always_comb begin
        desc          = '0;
        has_result    = 1'b0;
        res_bits_next = res_bits_reg;
        res_cnt_next  = res_cnt_reg;
        tail          = '0;

        if (mode_reg == MODE_ENCODE) begin
            has_result      = 1'b1;
            desc.data_valid = 1'b1;
            case (res_cnt_reg)
                HELD_2: begin
                    desc.chars[0] = b64sc_enc_char({res_bits_reg[1:0], s_in_byte[7:4]});
                    desc.last_idx = 2'd0;
                    res_bits_next = {2'b00, s_in_byte[3:0]};
                    res_cnt_next  = HELD_4;
                end
                HELD_4: begin
                    desc.chars[0] = b64sc_enc_char({res_bits_reg[3:0], s_in_byte[7:6]});
                    desc.chars[1] = b64sc_enc_char(s_in_byte[5:0]);
                    desc.last_idx = 2'd1;
                    res_bits_next = '0;
                    res_cnt_next  = HELD_0;
                end
                default: begin
                    desc.chars[0] = b64sc_enc_char(s_in_byte[7:2]);
                    desc.last_idx = 2'd0;
                    res_bits_next = {4'b0000, s_in_byte[1:0]};
                    res_cnt_next  = HELD_2;
                end
            endcase
            if (s_end_of_string) begin
                desc.run_last = 1'b1;
                // flush the partial character, then pad to a group of four
                case (res_cnt_next)
                    HELD_2: begin
                        tail                     = {res_bits_next[1:0], 4'b0000};
                        desc.chars[desc.last_idx + 2'd1] = b64sc_enc_char(tail);
                        desc.chars[desc.last_idx + 2'd2] = PAD_CHAR;
                        desc.chars[desc.last_idx + 2'd3] = PAD_CHAR;
                        desc.last_idx            = desc.last_idx + 2'd3;
                    end
                    HELD_4: begin
                        tail                     = {res_bits_next[3:0], 2'b00};
                        desc.chars[desc.last_idx + 2'd1] = b64sc_enc_char(tail);
                        desc.chars[desc.last_idx + 2'd2] = PAD_CHAR;
                        desc.last_idx            = desc.last_idx + 2'd2;
                    end
                    default: ;
                endcase
                res_bits_next = '0;
                res_cnt_next  = HELD_0;
            end
        end else begin
            desc.last_idx = 2'd0;
            if (sym_ok) begin
                case (res_cnt_reg)
                    HELD_2: begin
                        desc.chars[0]   = {res_bits_reg[1:0], sym};
                        desc.data_valid = 1'b1;
                        has_result      = 1'b1;
                        res_bits_next   = '0;
                        res_cnt_next    = HELD_0;
                    end
                    HELD_4: begin
                        desc.chars[0]   = {res_bits_reg[3:0], sym[5:2]};
                        desc.data_valid = 1'b1;
                        has_result      = 1'b1;
                        res_bits_next   = {4'b0000, sym[1:0]};
                        res_cnt_next    = HELD_2;
                    end
                    HELD_6: begin
                        desc.chars[0]   = {res_bits_reg, sym[5:4]};
                        desc.data_valid = 1'b1;
                        has_result      = 1'b1;
                        res_bits_next   = {2'b00, sym[3:0]};
                        res_cnt_next    = HELD_4;
                    end
                    default: begin
                        res_bits_next = sym;
                        res_cnt_next  = HELD_6;
                    end
                endcase
            end
            if (s_end_of_string) begin
                // always one beat at end of string, data flag may be clear
                has_result    = 1'b1;
                desc.run_last = 1'b1;
                res_bits_next = '0;
                res_cnt_next  = HELD_0;
            end
        end
    end

    assign desc_valid = s_valid && has_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_ENCODE;
            res_bits_reg <= '0;
            res_cnt_reg  <= HELD_0;
        end else if (cfg_wr_en) begin
            mode_reg     <= b64sc_mode_t'(cfg_wr_data);
            res_bits_reg <= '0;
            res_cnt_reg  <= HELD_0;
        end else if (accept) begin
            res_bits_reg <= res_bits_next;
            res_cnt_reg  <= res_cnt_next;
        end
    end

endmodule

// File: hdl/b64sc_queue.sv
// ============================================================================
// b64sc_queue: descriptor queue between front and back end
// Small register FIFO; lets either side stall without the other.
// ============================================================================
module b64sc_queue
    import b64sc_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  b64sc_desc_t in_desc,
    output logic        out_valid,
    input  logic        out_pop,
    output b64sc_desc_t out_desc
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    b64sc_desc_t   store_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push, pop;

    assign in_ready  = (count_reg != FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign out_desc  = store_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push)
            store_reg[wr_ptr_reg] <= in_desc;
    end

endmodule

// File: hdl/b64sc_back.sv
// ============================================================================
// b64sc_back: output stage of the base64 stream codec
// Walks the head descriptor one result per beat into the output register.
// ============================================================================
module b64sc_back
    import b64sc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        desc_valid,
    output logic        desc_pop,
    input  b64sc_desc_t desc,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_out_valid,
    output logic        m_run_last
);

    logic [1:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] byte_reg;
    logic       data_valid_reg;
    logic       run_last_reg;
    logic       load;
    logic       at_end;

    assign load     = desc_valid && (!m_valid_reg || m_ready);
    assign at_end   = (idx_reg == desc.last_idx);
    assign desc_pop = load && at_end;

    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            idx_next     = at_end ? 2'd0 : idx_reg + 2'd1;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg       <= desc.chars[idx_reg];
            data_valid_reg <= desc.data_valid;
            run_last_reg   <= desc.run_last && at_end;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = byte_reg;
    assign m_out_valid = data_valid_reg;
    assign m_run_last  = run_last_reg;

endmodule

// File: hdl/base64_stream_codec_top.sv
// An accepted input beat goes through the descriptor queue to the output register.
// Throughput: one result beat per cycle from the output register unless m_ready
// is low; an encoded byte gives 1 or 2 beats (up to 4 at end of string), a
// decoded char 0 or 1. Input is taken every cycle while the descriptor queue
// has room. Reset (aresetn low, synchronous): encode mode, no leftover bits,
// queue and output register empty.
// ============================================================================
// base64_stream_codec_top: streaming base64 encoder / decoder
// Front end classifies beats and builds result descriptors, a short queue
// decouples it from the back end that emits one result per beat.
// ============================================================================
module base64_stream_codec_top
    import b64sc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_string,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_valid,
    output logic       m_run_last
);

    b64sc_desc_t push_desc, head_desc;
    logic        push_valid, push_ready;
    logic        head_valid, head_pop;

    b64sc_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_end_of_string (s_end_of_string),
        .desc_valid      (push_valid),
        .desc_ready      (push_ready),
        .desc            (push_desc)
    );

    b64sc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_desc   (push_desc),
        .out_valid (head_valid),
        .out_pop   (head_pop),
        .out_desc  (head_desc)
    );

    b64sc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .desc_valid  (head_valid),
        .desc_pop    (head_pop),
        .desc        (head_desc),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_valid (m_out_valid),
        .m_run_last  (m_run_last)
    );

endmodule
